// File: sv/idp_pkg.sv
// Shared types and constants for the ID3v2 text frame parser.
// No dependencies.
`default_nettype none

package idp_pkg;

  localparam int unsigned SIZE_COUNT_BITS = 16;
  localparam int unsigned CNT_W = SIZE_COUNT_BITS;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW = QUEUE_AW + 1;

  localparam logic [15:0] MAX_FRAME_SIZE_RST = 16'd5000;
  localparam logic [0:0]  REG_MAX_FRAME_SIZE = 1'b0;

  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_Z    = 8'h5A;
  localparam logic [7:0] ENC_UTF16 = 8'h01;

  localparam logic [31:0] ID_TIT2 = 32'h54495432;
  localparam logic [31:0] ID_TPE1 = 32'h54504531;
  localparam logic [31:0] ID_TALB = 32'h54414C42;
  localparam logic [31:0] ID_TYER = 32'h54594552;
  localparam logic [31:0] ID_TCON = 32'h54434F4E;

  typedef enum logic [2:0] {
    EV_HEADER   = 3'd0,
    EV_TEXT     = 3'd1,
    EV_FRAME_END = 3'd2,
    EV_BAD_ID   = 3'd3,
    EV_BAD_SIZE = 3'd4,
    EV_EOF      = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    FK_TITLE  = 3'd0,
    FK_ARTIST = 3'd1,
    FK_ALBUM  = 3'd2,
    FK_YEAR   = 3'd3,
    FK_GENRE  = 3'd4
  } field_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       has_id3;
    logic [2:0] field_kind;
    logic [7:0] text_byte;
    logic       field_end;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: sv/idp_front.sv
// Front end: header, frame id/size/flags and data byte parsing.
// Pushes one result request per emitting byte into the queue. Uses idp_pkg.
`default_nettype none

module idp_front import idp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire in_t         item_i,
  input  wire logic [15:0] max_frame_size_i,
  output logic             push_o,
  output res_t             push_data_o
);

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_FLAG = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_STOP = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [23:0]      id_q, id_d;
  logic [31:0]      size_q, size_d;
  logic             enc_q, enc_d;
  logic             nul_q, nul_d;
  logic             id3_q, id3_d;
  logic [2:0]       kind_q, kind_d;
  logic             known_q, known_d;

  logic [7:0]       b;
  logic [31:0]      full_id;
  logic [31:0]      sz_next;
  logic             size_bad;
  logic             last;
  logic             text_pos;
  logic [CNT_W-1:0] count_inc;

  assign b         = item_i.data_byte;
  assign full_id   = {id_q, b};
  assign sz_next   = {size_q[23:0], b};
  assign count_inc = count_q + CNT_W'(1);
  assign size_bad  = (sz_next == 32'd0) || (sz_next > {16'd0, max_frame_size_i}) ||
                     ({1'b0, sz_next} > (33'd1 << SIZE_COUNT_BITS));
  assign last      = ({1'b0, size_q} == (33'(count_q) + 33'd1));

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    id_d        = id_q;
    size_d      = size_q;
    enc_d       = enc_q;
    nul_d       = nul_q;
    id3_d       = id3_q;
    kind_d      = kind_q;
    known_d     = known_q;
    text_pos    = 1'b0;
    push_o      = 1'b0;
    push_data_o = '0;

    if (accept_i) begin
      if (item_i.end_marker) begin
        push_o                = 1'b1;
        push_data_o.event_res = EV_EOF;
        push_data_o.has_id3   = (phase_q == PH_HDR) ? 1'b0 : id3_q;
        phase_d = PH_HDR;
        count_d = '0;
        id_d    = '0;
        size_d  = '0;
        enc_d   = 1'b0;
        nul_d   = 1'b0;
        id3_d   = 1'b0;
        kind_d  = FK_TITLE;
        known_d = 1'b0;
      end else begin
        case (phase_q)
          PH_HDR: begin
            if (count_q == CNT_W'(0)) begin
              id3_d = (b == CH_I);
            end else if (count_q == CNT_W'(1)) begin
              id3_d = id3_q && (b == CH_D);
            end else if (count_q == CNT_W'(2)) begin
              id3_d = id3_q && (b == CH_3);
            end
            count_d = count_inc;
            if (count_q == CNT_W'(9)) begin
              phase_d               = PH_ID;
              count_d               = '0;
              push_o                = 1'b1;
              push_data_o.event_res = EV_HEADER;
              push_data_o.has_id3   = id3_d;
            end
          end
          PH_ID: begin
            id_d    = full_id[23:0];
            count_d = count_inc;
            if (count_q == CNT_W'(3)) begin
              count_d = '0;
              known_d = 1'b1;
              case (full_id)
                ID_TIT2: kind_d = FK_TITLE;
                ID_TPE1: kind_d = FK_ARTIST;
                ID_TALB: kind_d = FK_ALBUM;
                ID_TYER: kind_d = FK_YEAR;
                ID_TCON: kind_d = FK_GENRE;
                default: begin
                  kind_d  = FK_TITLE;
                  known_d = 1'b0;
                end
              endcase
              if (id_q[23:16] < CH_A || id_q[23:16] > CH_Z) begin
                phase_d               = PH_STOP;
                push_o                = 1'b1;
                push_data_o.event_res = EV_BAD_ID;
                push_data_o.has_id3   = id3_q;
              end else begin
                phase_d = PH_SIZE;
              end
            end
          end
          PH_SIZE: begin
            size_d  = sz_next;
            count_d = count_inc;
            if (count_q == CNT_W'(3)) begin
              count_d = '0;
              if (size_bad) begin
                phase_d               = PH_STOP;
                push_o                = 1'b1;
                push_data_o.event_res = EV_BAD_SIZE;
                push_data_o.has_id3   = id3_q;
              end else begin
                phase_d = PH_FLAG;
              end
            end
          end
          PH_FLAG: begin
            count_d = count_inc;
            if (count_q == CNT_W'(1)) begin
              phase_d = PH_DATA;
              count_d = '0;
              nul_d   = 1'b0;
              enc_d   = 1'b0;
            end
          end
          PH_DATA: begin
            if (count_q == CNT_W'(0)) begin
              enc_d    = (b == ENC_UTF16);
              text_pos = 1'b0;
            end else if (enc_q) begin
              text_pos = count_q[0] && (count_q != CNT_W'(1));
            end else begin
              text_pos = 1'b1;
            end
            if (text_pos && !nul_q && (b == 8'd0)) begin
              nul_d = 1'b1;
            end
            count_d = count_inc;
            if (last) begin
              phase_d = PH_ID;
              count_d = '0;
            end
            if (known_q) begin
              if (text_pos && !nul_q && (b != 8'd0)) begin
                push_o                 = 1'b1;
                push_data_o.event_res  = EV_TEXT;
                push_data_o.has_id3    = id3_q;
                push_data_o.field_kind = kind_q;
                push_data_o.text_byte  = b;
                push_data_o.field_end  = last;
              end else if (last) begin
                push_o                 = 1'b1;
                push_data_o.event_res  = EV_FRAME_END;
                push_data_o.has_id3    = id3_q;
                push_data_o.field_kind = kind_q;
                push_data_o.field_end  = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      count_q <= '0;
      id_q    <= '0;
      size_q  <= '0;
      enc_q   <= 1'b0;
      nul_q   <= 1'b0;
      id3_q   <= 1'b0;
      kind_q  <= FK_TITLE;
      known_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      id_q    <= id_d;
      size_q  <= size_d;
      enc_q   <= enc_d;
      nul_q   <= nul_d;
      id3_q   <= id3_d;
      kind_q  <= kind_d;
      known_q <= known_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/idp_fifo.sv
// Short request queue between the parsing front end and the output stage.
// Uses idp_pkg.
`default_nettype none

module idp_fifo import idp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire res_t  push_data_i,
  input  wire logic  pop_i,
  output res_t       head_o,
  output q_status_t  status_o
);

  res_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QUEUE_CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !status_o.empty)
    else $error("queue lost a request");

endmodule

`default_nettype wire

// File: sv/idp_back.sv
// Output stage: pops queued requests, cleans unused fields, holds the result
// register for the out channel. Uses idp_pkg.
`default_nettype none

module idp_back import idp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_t      head_i,
  input  wire q_status_t status_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output res_t           out_data_o
);

  logic out_valid_q, out_valid_d;
  res_t out_data_q, out_data_d;
  logic is_text, is_frame;

  assign is_text  = (head_i.event_res == EV_TEXT);
  assign is_frame = is_text || (head_i.event_res == EV_FRAME_END);
  assign pop_o    = !status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop_o) begin
      out_valid_d           = 1'b1;
      out_data_d.event_res  = head_i.event_res;
      out_data_d.has_id3    = head_i.has_id3;
      out_data_d.field_kind = is_frame ? head_i.field_kind : 3'd0;
      out_data_d.text_byte  = is_text ? head_i.text_byte : 8'd0;
      out_data_d.field_end  = is_frame && head_i.field_end;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: sv/id3v2_text_frame_parser_core.sv
// Top level of the ID3v2 text frame parser: config register, front end,
// request queue and output stage. Uses idp_pkg, idp_front, idp_fifo, idp_back.
// Throughput: one byte per clock; in_stall_o rises only when the 2-entry queue is full.
// Path: results go through the request queue, then the out_data_o register.
// Reset: rst_ni clears parser state to the header phase; max_frame_size resets to 5000.
`default_nettype none

module id3v2_text_frame_parser_core import idp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output res_t             out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        max_size_we;
  logic [15:0] max_size_q, max_size_d;
  logic        accept;
  logic        push;
  res_t        push_data;
  logic        pop;
  res_t        head;
  q_status_t   q_status;

  assign pready      = 1'b1;
  assign max_size_we = psel && penable && pwrite && (paddr[2] == REG_MAX_FRAME_SIZE);
  assign max_size_d  = max_size_we ? pwdata[15:0] : max_size_q;
  assign prdata      = (paddr[2] == REG_MAX_FRAME_SIZE) ? {16'd0, max_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MAX_FRAME_SIZE_RST;
    end else begin
      max_size_q <= max_size_d;
    end
  end

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !q_status.full;

  idp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .item_i           (in_data_i),
    .max_frame_size_i (max_size_q),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  idp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  idp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
